[rtl/iirdf2_pkg.sv]
// Shared types and constants of the direct form II IIR filter.
// Depends on nothing; every other file of the block imports it.
package iirdf2_pkg;

   // Fixed field and arithmetic widths.
   localparam int SAMPLE_W  = 24;
   localparam int COEF_W    = 32;
   localparam int DL_W      = 40;
   localparam int FRAC_BITS = 28;
   localparam int PROD_W    = COEF_W + DL_W;
   localparam int ACC_W     = PROD_W + 3;
   localparam int RND_W     = ACC_W - FRAC_BITS;
   localparam int HEAD_W    = RND_W + 1;
   localparam int LIM_W     = FRAC_BITS + 1;
   localparam int MAG_W     = FRAC_BITS;
   localparam int NUM_W     = MAG_W + FRAC_BITS;
   localparam int QUO_W     = SAMPLE_W + 1;
   localparam int DIV_STEPS = QUO_W;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);
   localparam int REM_W     = COEF_W;
   localparam int CIDX_W    = 2;

   // Register file layout.
   localparam int ADDR_W = 5;
   localparam logic [2:0] REG_DEN_COEF_0 = 3'd0;
   localparam logic [2:0] REG_NUM_COEF_0 = 3'd4;

   // Constants of the arithmetic.
   localparam logic signed [COEF_W-1:0] COEF_ONE   = 32'sh1000_0000;
   localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [HEAD_W-1:0] DL_MAX     = (HEAD_W'(1) <<< (DL_W - 1)) - HEAD_W'(1);
   localparam logic signed [HEAD_W-1:0] DL_MIN     = -(HEAD_W'(1) <<< (DL_W - 1));
   localparam logic signed [RND_W-1:0]  ACC_LIM    = RND_W'(1) <<< (FRAC_BITS - 1);
   localparam logic [QUO_W-1:0]         POS_LIM    = (QUO_W'(1) << (SAMPLE_W - 1)) - QUO_W'(1);
   localparam logic [QUO_W-1:0]         NEG_LIM    = QUO_W'(1) << (SAMPLE_W - 1);
   localparam logic signed [SAMPLE_W-1:0] OUT_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] OUT_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef coef_type [3:0] coef_bank_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FB_MUL,
      ST_FB_ACC,
      ST_HEAD,
      ST_FF_MUL,
      ST_FF_ACC,
      ST_NORM,
      ST_DIV,
      ST_FIN
   } state_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic take;      // latch the word and shift the delay line
      logic mul_fb;    // multiply feedback coefficient by delay entry
      logic mul_ff;    // multiply feed-forward coefficient by delay entry
      logic acc_add;   // add the registered product to the accumulator
      logic head_wr;   // write the new delay head, clear the accumulator
      logic norm;      // round, clamp and set up the division
      logic div_step;  // one quotient bit
      logic load_out;  // load the result register
   } dp_cmd_type;

endpackage

[rtl/iir_direct_form_ii_filter.sv]
// Top level of the direct form II IIR filter with TAPS delay entries.
// Depends on iirdf2_pkg, iirdf2_csr, iirdf2_ctrl and iirdf2_dp.
//
// Usage. Input words arrive on the req_ channel (valid/ready) and carry one
// signed 24-bit sample and a block-end marker. Each accepted word gives
// exactly one result word on the rsp_ channel (valid/ready) with the
// filtered, saturated sample, the copied marker and a clip flag.
// Coefficients are Q4.28 values written through the csr_ port at byte
// address 4*i; they should only change while no word is in flight.
//
// Timing. The block works on one word at a time. A single multiplier and
// accumulator walk the taps, a multiply step then an accumulate step per
// product, and a restoring divider produces one quotient bit per cycle for
// the output scaling by a0. A new word is taken only after the result of
// the last one is loaded. When a0 is zero or the quotient is known to
// saturate, the divider steps are skipped.
//
// Reset (synchronous, active high) clears the delay line, loads a0 and b0
// with 1.0 and all other coefficients with zero. While the receiver stalls,
// the finished word is held in the output register; the block still accepts
// the next input word and computes it, then waits before loading its result.
module iir_direct_form_ii_filter import iirdf2_pkg::*; #(
   parameter int TAPS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic                       req_block_end_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_block_end_out,
   output logic                       rsp_clipped,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [ADDR_W-1:0]          csr_paddr,
   input  logic [COEF_W-1:0]          csr_pwdata,
   output logic [COEF_W-1:0]          csr_prdata,
   output logic                       csr_pready
);

   localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;

   coef_bank_type    den_coef;
   coef_bank_type    num_coef;
   dp_cmd_type       cmd;
   logic [IDX_W-1:0] idx;
   logic             skip_div;

   // Coefficient registers, readable and writable at any time.
   iirdf2_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready),
      .den_coef (den_coef),
      .num_coef (num_coef)
   );

   // The sequencer owns both handshakes and steps the datapath.
   iirdf2_ctrl #(
      .TAPS (TAPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .skip_div  (skip_div),
      .cmd       (cmd),
      .idx       (idx)
   );

   // The datapath holds the delay line and the result register.
   iirdf2_dp #(
      .TAPS (TAPS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .idx           (idx),
      .sample_in     (req_sample_in),
      .block_end_in  (req_block_end_in),
      .den_coef      (den_coef),
      .num_coef      (num_coef),
      .skip_div      (skip_div),
      .sample_out    (rsp_sample_out),
      .block_end_out (rsp_block_end_out),
      .clipped       (rsp_clipped)
   );

   // Once a word is taken, the block is busy for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted on two consecutive cycles");

   // A new result only appears at the end of the work on a word.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while the block was idle");

endmodule

[rtl/iirdf2_csr.sv]
// APB-style coefficient register file of the IIR filter.
// Depends on iirdf2_pkg for the register layout and coefficient types.
module iirdf2_csr import iirdf2_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [COEF_W-1:0]   pwdata,
   output logic [COEF_W-1:0]   prdata,
   output logic                pready,
   output coef_bank_type       den_coef,
   output coef_bank_type       num_coef
);

   coef_bank_type den_coef_ff, den_coef_in;
   coef_bank_type num_coef_ff, num_coef_in;
   logic [2:0]        reg_idx;
   logic [CIDX_W-1:0] bank_idx;
   logic              wr_en;

   assign reg_idx  = paddr[ADDR_W-1:2];
   assign bank_idx = reg_idx[CIDX_W-1:0];
   assign wr_en    = psel & penable & pwrite;
   assign pready   = 1'b1;

   always_comb begin
      den_coef_in = den_coef_ff;
      num_coef_in = num_coef_ff;
      if (wr_en) begin
         if (reg_idx < REG_NUM_COEF_0) begin
            den_coef_in[bank_idx] = coef_type'(pwdata);
         end else begin
            num_coef_in[bank_idx] = coef_type'(pwdata);
         end
      end
   end

   // Entry zero of each bank comes out of reset at 1.0, the others at zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         den_coef_ff <= {{(3*COEF_W){1'b0}}, COEF_ONE};
         num_coef_ff <= {{(3*COEF_W){1'b0}}, COEF_ONE};
      end else begin
         den_coef_ff <= den_coef_in;
         num_coef_ff <= num_coef_in;
      end
   end

   // Registers at or above the first feed-forward index read the second bank.
   assign prdata   = (reg_idx < REG_NUM_COEF_0) ? den_coef_ff[bank_idx] : num_coef_ff[bank_idx];
   assign den_coef = den_coef_ff;
   assign num_coef = num_coef_ff;

endmodule

[rtl/iirdf2_ctrl.sv]
// Sequencer of the IIR filter: walks the taps, the division and the handoff.
// Depends on iirdf2_pkg for the state and command types.
module iirdf2_ctrl import iirdf2_pkg::*; #(
   parameter  int TAPS  = 4,
   localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             skip_div,
   output dp_cmd_type       cmd,
   output logic [IDX_W-1:0] idx
);

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TAPS - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (TAPS > 1) begin
                  idx_in   = IDX_W'(1);
                  state_in = ST_FB_MUL;
               end else begin
                  state_in = ST_HEAD;
               end
            end
         end
         ST_FB_MUL: begin
            cmd.mul_fb = 1'b1;
            state_in   = ST_FB_ACC;
         end
         ST_FB_ACC: begin
            cmd.acc_add = 1'b1;
            if (idx_ff == IDX_LAST) begin
               state_in = ST_HEAD;
            end else begin
               idx_in   = IDX_W'(idx_ff + 1'b1);
               state_in = ST_FB_MUL;
            end
         end
         ST_HEAD: begin
            cmd.head_wr = 1'b1;
            idx_in      = '0;
            state_in    = ST_FF_MUL;
         end
         ST_FF_MUL: begin
            cmd.mul_ff = 1'b1;
            state_in   = ST_FF_ACC;
         end
         ST_FF_ACC: begin
            cmd.acc_add = 1'b1;
            if (idx_ff == IDX_LAST) begin
               state_in = ST_NORM;
            end else begin
               idx_in   = IDX_W'(idx_ff + 1'b1);
               state_in = ST_FF_MUL;
            end
         end
         ST_NORM: begin
            cmd.norm = 1'b1;
            if (skip_div) begin
               state_in = ST_FIN;
            end else begin
               cnt_in   = CNT_W'(DIV_STEPS);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = CNT_W'(cnt_ff - 1'b1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign idx          = idx_ff;

endmodule

[rtl/iirdf2_dp.sv]
// Datapath of the IIR filter: delay line, shared multiply-accumulate unit,
// rounding and saturation, and a restoring divider for the output scaling.
// Depends on iirdf2_pkg for widths, constants and the command struct.
module iirdf2_dp import iirdf2_pkg::*; #(
   parameter  int TAPS  = 4,
   localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   input  logic [IDX_W-1:0]           idx,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   input  logic                       block_end_in,
   input  coef_bank_type              den_coef,
   input  coef_bank_type              num_coef,
   output logic                       skip_div,
   output logic signed [SAMPLE_W-1:0] sample_out,
   output logic                       block_end_out,
   output logic                       clipped
);

   logic signed [DL_W-1:0]     dl_ff [TAPS];
   logic signed [DL_W-1:0]     dl_in [TAPS];
   logic signed [SAMPLE_W-1:0] x_ff;
   logic                       blk_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       clip_ff;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [QUO_W-1:0]           qn_ff;
   logic                       neg_ff, force_ff, force_neg_ff;
   logic signed [SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic                       out_blk_ff;
   logic                       out_clip_ff, out_clip_in;

   logic [CIDX_W-1:0]        cidx;
   logic signed [COEF_W-1:0] coef_mul;
   logic signed [ACC_W-1:0]  acc_half;
   logic signed [RND_W-1:0]  rnd;
   logic signed [HEAD_W-1:0] head_wide;
   logic signed [DL_W-1:0]   head_sat;
   logic                     head_clip;
   logic signed [RND_W-1:0]  rnd_lim;
   logic signed [LIM_W-1:0]  acc_clamp;
   logic                     acc_neg;
   logic [MAG_W-1:0]         acc_mag;
   logic signed [COEF_W-1:0] den0;
   logic                     den_neg, den_zero;
   logic [REM_W-1:0]         den_mag;
   logic [NUM_W-1:0]         num_sum;
   logic                     quo_ovf;
   logic [REM_W:0]           rem_shift;
   logic                     rem_ge;

   // Multiply operands: the coefficient bank follows the phase of the tap walk.
   assign cidx     = CIDX_W'(idx);
   assign coef_mul = cmd.mul_fb ? den_coef[cidx] : num_coef[cidx];

   // Round the accumulated sum to sample units, halves toward plus infinity.
   assign acc_half = acc_ff + ROUND_HALF;
   assign rnd      = $signed(acc_half[ACC_W-1:FRAC_BITS]);

   // New delay head: sample minus rounded feedback, saturated to the line width.
   assign head_wide = HEAD_W'(x_ff) - HEAD_W'(rnd);
   always_comb begin
      head_clip = 1'b0;
      head_sat  = DL_W'(head_wide);
      if (head_wide > DL_MAX) begin
         head_clip = 1'b1;
         head_sat  = DL_W'(DL_MAX);
      end else if (head_wide < DL_MIN) begin
         head_clip = 1'b1;
         head_sat  = DL_W'(DL_MIN);
      end
   end

   // Output scaling setup: clamp, split into sign and magnitude, add half divisor.
   always_comb begin
      rnd_lim = rnd;
      if (rnd > ACC_LIM) begin
         rnd_lim = ACC_LIM;
      end else if (rnd < -ACC_LIM) begin
         rnd_lim = -ACC_LIM;
      end
   end
   assign acc_clamp = LIM_W'(rnd_lim);
   assign acc_neg   = acc_clamp[LIM_W-1];
   assign acc_mag   = acc_neg ? MAG_W'(-acc_clamp) : MAG_W'(acc_clamp);
   assign den0      = den_coef[0];
   assign den_neg   = den0[COEF_W-1];
   assign den_zero  = (den0 == '0);
   assign den_mag   = den_neg ? REM_W'(-den0) : REM_W'(den0);
   assign num_sum   = {acc_mag, {FRAC_BITS{1'b0}}} + NUM_W'(den_mag >> 1);
   // Any quotient of 2^25 or more saturates the output, so the divider never runs.
   assign quo_ovf   = {1'b0, num_sum[NUM_W-1:QUO_W]} >= den_mag;
   assign skip_div  = den_zero | quo_ovf;

   // One restoring division step per cycle.
   assign rem_shift = {rem_ff, qn_ff[QUO_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, den_mag};
   assign rem_in    = rem_ge ? REM_W'(rem_shift - {1'b0, den_mag}) : rem_shift[REM_W-1:0];

   // Final saturation and sign of the scaled result.
   always_comb begin
      out_clip_in   = clip_ff;
      out_sample_in = SAMPLE_W'(qn_ff);
      if (force_ff) begin
         out_clip_in   = 1'b1;
         out_sample_in = force_neg_ff ? OUT_MIN : OUT_MAX;
      end else if (neg_ff) begin
         if (qn_ff > NEG_LIM) begin
            out_clip_in   = 1'b1;
            out_sample_in = OUT_MIN;
         end else begin
            out_sample_in = SAMPLE_W'(-qn_ff);
         end
      end else if (qn_ff > POS_LIM) begin
         out_clip_in   = 1'b1;
         out_sample_in = OUT_MAX;
      end
   end

   // Delay line: shift on a new word, then the head is written once it is known.
   always_comb begin
      for (int n = 0; n < TAPS; n++) begin
         dl_in[n] = dl_ff[n];
      end
      if (cmd.take) begin
         dl_in[0] = '0;
         for (int n = 1; n < TAPS; n++) begin
            dl_in[n] = dl_ff[n-1];
         end
      end else if (cmd.head_wr) begin
         dl_in[0] = head_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < TAPS; n++) begin
            dl_ff[n] <= '0;
         end
      end else begin
         for (int n = 0; n < TAPS; n++) begin
            dl_ff[n] <= dl_in[n];
         end
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.take || cmd.head_wr) begin
         acc_in = '0;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.take) begin
         x_ff   <= sample_in;
         blk_ff <= block_end_in;
      end
      if (cmd.mul_fb || cmd.mul_ff) begin
         prod_ff <= PROD_W'(coef_mul) * PROD_W'(dl_ff[idx]);
      end
      if (cmd.head_wr) begin
         clip_ff <= head_clip;
      end
      if (cmd.norm) begin
         rem_ff       <= REM_W'(num_sum[NUM_W-1:QUO_W]);
         qn_ff        <= num_sum[QUO_W-1:0];
         neg_ff       <= acc_neg ^ den_neg;
         force_ff     <= den_zero | quo_ovf;
         force_neg_ff <= den_zero ? acc_neg : (acc_neg ^ den_neg);
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         qn_ff  <= {qn_ff[QUO_W-2:0], rem_ge};
      end
      if (cmd.load_out) begin
         out_sample_ff <= out_sample_in;
         out_blk_ff    <= blk_ff;
         out_clip_ff   <= out_clip_in;
      end
   end

   assign sample_out    = out_sample_ff;
   assign block_end_out = out_blk_ff;
   assign clipped       = out_clip_ff;

endmodule

[verif/iir_direct_form_ii_filter_tb.sv]
// Self-checking testbench for the direct form II IIR filter: a directed table, then
// random words under changing coefficient sets, checked against a bit-exact predictor.
// Depends on iirdf2_pkg and iir_direct_form_ii_filter.
`timescale 1ns / 1ps

module iir_direct_form_ii_filter_tb;
   import iirdf2_pkg::*;

   localparam int TAPS        = 4;
   localparam int N_REGS      = 8;
   localparam int N_STEPS     = 44;
   localparam int N_PHASES    = 8;
   localparam int PHASE_WORDS = 150;
   // The long receiver hold-off must fit well inside the watchdog window.
   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT = 3000;
   // The tail wait covers the time a word takes from accept to result.
   localparam int TAIL_CYCLES = 4 * TAPS + 40;

   // The predictor works in 80-bit signed arithmetic, wide enough for the exact sum
   // of four 32 x 40 bit products.
   typedef logic signed [79:0] wide_type;
   localparam wide_type HALF_LSB = wide_type'(1) <<< (FRAC_BITS - 1);
   localparam wide_type TAP_HI   = (wide_type'(1) <<< (DL_W - 1)) - wide_type'(1);
   localparam wide_type TAP_LO   = -(wide_type'(1) <<< (DL_W - 1));
   localparam wide_type ACC_CAP  = wide_type'(1) <<< (FRAC_BITS - 1);

   // Register map: four denominator coefficients (a0 first), then four numerator ones.
   typedef enum logic [2:0] {
      CSR_DEN0 = REG_DEN_COEF_0, CSR_DEN1, CSR_DEN2, CSR_DEN3,
      CSR_NUM0 = REG_NUM_COEF_0, CSR_NUM1, CSR_NUM2, CSR_NUM3
   } csr_reg_type;

   // Directed rows either write a register, send a word whose result is typed in,
   // or send a word whose result comes from the predictor.
   typedef enum logic [1:0] {STEP_CSR, STEP_FIXED, STEP_PRED} step_kind_type;

   // Coefficient flavors of the random phases.
   typedef enum int {CFG_TAME, CFG_WILD, CFG_EDGE, CFG_TINY_A0} cfg_mode_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] smp;
      logic                       be;
      logic                       clip;
   } filter_word_type;

   typedef struct packed {
      step_kind_type              kind;
      csr_reg_type                reg_id;
      coef_type                   coef;
      logic signed [SAMPLE_W-1:0] smp;
      logic                       be;
      logic signed [SAMPLE_W-1:0] want_smp;
      logic                       want_clip;
   } step_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       req_block_end_in = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_block_end_out;
   logic                       rsp_clipped;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]          csr_paddr = '0;
   logic [COEF_W-1:0]          csr_pwdata = '0;
   logic [COEF_W-1:0]          csr_prdata;
   logic                       csr_pready;

   // Predictor state: its own delay line and coefficient copies. den_q28[0] is the
   // output normalizer a0, which never enters the feedback sum.
   logic signed [DL_W-1:0] delay_taps [TAPS];
   coef_type               den_q28 [4];
   coef_type               num_q28 [4];

   filter_word_type pending_words [$];
   int              error_count = 0;
   int              result_count = 0;
   int              quiet_cycles = 0;
   bit              calm = 1'b0;
   bit              hold_wanted = 1'b0;
   bit              hold_used = 1'b0;
   int              hold_left = 0;

   // Directed table. Under the reset coefficients the filter is the identity, a zero
   // normalizer pins the output to the rail that matches the sign of the accumulator,
   // and a0 = -1.0 negates; those results are typed in. The rows after them probe the
   // two rounding rules, the most negative a0, and all-extreme coefficient sets that
   // drive the delay head into saturation.
   step_type directed_steps [N_STEPS] = '{
      '{STEP_FIXED, CSR_DEN0, '0, 24'sd0, 1'b0, 24'sd0, 1'b0},
      '{STEP_FIXED, CSR_DEN0, '0, 24'sd1, 1'b1, 24'sd1, 1'b0},
      '{STEP_FIXED, CSR_DEN0, '0, -24'sd1, 1'b0, -24'sd1, 1'b0},
      '{STEP_FIXED, CSR_DEN0, '0, OUT_MAX, 1'b1, OUT_MAX, 1'b0},
      '{STEP_FIXED, CSR_DEN0, '0, OUT_MIN, 1'b0, OUT_MIN, 1'b0},
      '{STEP_FIXED, CSR_DEN0, '0, 24'sh555555, 1'b1, 24'sh555555, 1'b0},
      '{STEP_FIXED, CSR_DEN0, '0, 24'shAAAAAA, 1'b0, 24'shAAAAAA, 1'b0},
      '{STEP_CSR, CSR_DEN0, 32'sh0000_0000, '0, 1'b0, '0, 1'b0},
      '{STEP_FIXED, CSR_DEN0, '0, 24'sd5, 1'b0, OUT_MAX, 1'b1},
      '{STEP_FIXED, CSR_DEN0, '0, 24'sd0, 1'b1, OUT_MAX, 1'b1},
      '{STEP_FIXED, CSR_DEN0, '0, -24'sd1, 1'b0, OUT_MIN, 1'b1},
      '{STEP_CSR, CSR_DEN0, 32'shF000_0000, '0, 1'b0, '0, 1'b0},
      '{STEP_FIXED, CSR_DEN0, '0, 24'sd100, 1'b0, -24'sd100, 1'b0},
      '{STEP_FIXED, CSR_DEN0, '0, OUT_MIN, 1'b1, OUT_MAX, 1'b1},
      '{STEP_CSR, CSR_DEN0, 32'sh2000_0000, '0, 1'b0, '0, 1'b0},
      '{STEP_PRED, CSR_DEN0, '0, 24'sd3, 1'b0, '0, 1'b0},
      '{STEP_PRED, CSR_DEN0, '0, -24'sd3, 1'b0, '0, 1'b0},
      '{STEP_CSR, CSR_DEN0, 32'sh1000_0000, '0, 1'b0, '0, 1'b0},
      '{STEP_CSR, CSR_NUM0, 32'sh0800_0000, '0, 1'b0, '0, 1'b0},
      '{STEP_PRED, CSR_DEN0, '0, 24'sd3, 1'b0, '0, 1'b0},
      '{STEP_PRED, CSR_DEN0, '0, -24'sd3, 1'b1, '0, 1'b0},
      '{STEP_CSR, CSR_DEN0, 32'sh8000_0000, '0, 1'b0, '0, 1'b0},
      '{STEP_CSR, CSR_NUM0, 32'sh7FFF_FFFF, '0, 1'b0, '0, 1'b0},
      '{STEP_PRED, CSR_DEN0, '0, 24'sd12, 1'b0, '0, 1'b0},
      '{STEP_PRED, CSR_DEN0, '0, OUT_MAX, 1'b1, '0, 1'b0},
      '{STEP_CSR, CSR_DEN0, 32'sh1000_0000, '0, 1'b0, '0, 1'b0},
      '{STEP_CSR, CSR_DEN1, 32'sh7FFF_FFFF, '0, 1'b0, '0, 1'b0},
      '{STEP_CSR, CSR_DEN2, 32'sh8000_0000, '0, 1'b0, '0, 1'b0},
      '{STEP_CSR, CSR_DEN3, 32'sh7FFF_FFFF, '0, 1'b0, '0, 1'b0},
      '{STEP_CSR, CSR_NUM1, 32'sh7FFF_FFFF, '0, 1'b0, '0, 1'b0},
      '{STEP_CSR, CSR_NUM2, 32'sh8000_0000, '0, 1'b0, '0, 1'b0},
      '{STEP_CSR, CSR_NUM3, 32'sh7FFF_FFFF, '0, 1'b0, '0, 1'b0},
      '{STEP_PRED, CSR_DEN0, '0, OUT_MAX, 1'b0, '0, 1'b0},
      '{STEP_PRED, CSR_DEN0, '0, OUT_MIN, 1'b0, '0, 1'b0},
      '{STEP_PRED, CSR_DEN0, '0, OUT_MAX, 1'b1, '0, 1'b0},
      '{STEP_PRED, CSR_DEN0, '0, 24'sd0, 1'b0, '0, 1'b0},
      '{STEP_CSR, CSR_DEN1, 32'sh8000_0000, '0, 1'b0, '0, 1'b0},
      '{STEP_CSR, CSR_DEN3, 32'sh8000_0000, '0, 1'b0, '0, 1'b0},
      '{STEP_CSR, CSR_NUM0, 32'sh8000_0000, '0, 1'b0, '0, 1'b0},
      '{STEP_CSR, CSR_NUM1, 32'sh8000_0000, '0, 1'b0, '0, 1'b0},
      '{STEP_CSR, CSR_NUM3, 32'sh8000_0000, '0, 1'b0, '0, 1'b0},
      '{STEP_PRED, CSR_DEN0, '0, OUT_MIN, 1'b0, '0, 1'b0},
      '{STEP_PRED, CSR_DEN0, '0, 24'sd1, 1'b0, '0, 1'b0},
      '{STEP_PRED, CSR_DEN0, '0, OUT_MAX, 1'b1, '0, 1'b0}
   };

   iir_direct_form_ii_filter #(
      .TAPS(TAPS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_in     (req_sample_in),
      .req_block_end_in  (req_block_end_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_block_end_out (rsp_block_end_out),
      .rsp_clipped       (rsp_clipped),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every mismatch is counted; only the first ten are printed.
   task automatic report(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // Round a Q28 sum to an integer, halves toward plus infinity.
   function automatic wide_type round_q28(input wide_type v);
      return (v + HALF_LSB) >>> FRAC_BITS;
   endfunction

   // One filter step: shift the delay line, form the new head from the sample and
   // the feedback taps, then the feed-forward sum scaled by 1/a0.
   function automatic filter_word_type next_filter_word(
      input logic signed [SAMPLE_W-1:0] smp, input logic be);
      wide_type        fb_sum, ff_sum, head, acc, cw, dw;
      longint          acc_l, den_l, nm, dm, q, y;
      logic            clip;
      filter_word_type w;
      clip = 1'b0;
      for (int n = TAPS - 1; n > 0; n--) begin
         delay_taps[n] = delay_taps[n - 1];
      end
      fb_sum = '0;
      for (int n = 1; n < TAPS; n++) begin
         cw = den_q28[n];
         dw = delay_taps[n];
         fb_sum = fb_sum + cw * dw;
      end
      head = smp;
      head = head - round_q28(fb_sum);
      if (head > TAP_HI) begin
         head = TAP_HI;
         clip = 1'b1;
      end else if (head < TAP_LO) begin
         head = TAP_LO;
         clip = 1'b1;
      end
      delay_taps[0] = head[DL_W-1:0];

      ff_sum = '0;
      for (int n = 0; n < TAPS; n++) begin
         cw = num_q28[n];
         dw = delay_taps[n];
         ff_sum = ff_sum + cw * dw;
      end
      // Clamping the accumulator never changes the output, it only bounds the divide.
      acc = round_q28(ff_sum);
      if (acc > ACC_CAP) acc = ACC_CAP;
      if (acc < -ACC_CAP) acc = -ACC_CAP;

      acc_l = longint'(acc);
      den_l = den_q28[0];
      if (den_l == 0) begin
         clip = 1'b1;
         y = (acc_l >= 0) ? longint'(OUT_MAX) : longint'(OUT_MIN);
      end else begin
         // Divide magnitudes with halves away from zero, then apply the sign.
         nm = (acc_l < 0 ? -acc_l : acc_l) <<< FRAC_BITS;
         dm = (den_l < 0) ? -den_l : den_l;
         q = (nm + dm / 2) / dm;
         y = ((acc_l < 0) != (den_l < 0)) ? -q : q;
         if (y > longint'(OUT_MAX)) begin
            y = OUT_MAX;
            clip = 1'b1;
         end else if (y < longint'(OUT_MIN)) begin
            y = OUT_MIN;
            clip = 1'b1;
         end
      end
      w.smp = y[SAMPLE_W-1:0];
      w.be = be;
      w.clip = clip;
      return w;
   endfunction

   function automatic coef_type spread(input int span);
      return coef_type'($urandom_range(2 * span) - span);
   endfunction

   // Coefficient for one register under a given random flavor. Tame sets keep the
   // feedback small enough to stay stable, so the filter spends time in range.
   function automatic coef_type rand_coef(input cfg_mode_type mode, input csr_reg_type r);
      coef_type a0;
      case (mode)
         CFG_WILD: return coef_type'($urandom());
         CFG_EDGE: begin
            case ($urandom_range(6))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return '0;
               3: return COEF_ONE;
               4: return -COEF_ONE;
               5: return 32'sd1;
               default: return -32'sd1;
            endcase
         end
         default: ;
      endcase
      if (r == CSR_DEN0) begin
         // A tiny normalizer, zero included, sends most outputs to the rails.
         if (mode == CFG_TINY_A0) return spread(16);
         a0 = coef_type'($urandom_range(COEF_ONE <<< 1, COEF_ONE >>> 1));
         return ($urandom_range(3) == 0) ? -a0 : a0;
      end
      return spread((r < CSR_NUM0) ? (1 << 26) : (1 << 27));
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(9))
         0: return OUT_MAX;
         1: return OUT_MIN;
         2, 3, 4: return SAMPLE_W'(int'($urandom_range(511)) - 256);
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   // Offer one word, holding valid and payload until it is taken. On the accept edge
   // the predictor advances and the expected result joins the queue.
   task automatic push_word(input logic signed [SAMPLE_W-1:0] smp, input logic be,
                            input bit typed, input filter_word_type typed_word);
      filter_word_type predicted;
      @(negedge clock);
      while (!calm && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= smp;
      req_block_end_in <= be;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = next_filter_word(smp, be);
      pending_words.insert(pending_words.size(), typed ? typed_word : predicted);
   endtask

   // Stop offering and wait until every outstanding word has come back, so that the
   // block is idle before the coefficients change.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // Write one coefficient (setup then access phase), then read it back.
   task automatic write_coef(input csr_reg_type r, input coef_type value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {r, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (r < CSR_NUM0) den_q28[r] = value;
      else num_q28[r - CSR_NUM0] = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== value) begin
         report($sformatf("register %s read back %h, expected %h", r.name(), csr_prdata,
                          value));
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Receiver: random stalls, none during the calm phase, and one long hold-off that
   // lets the block fill up while the sender keeps offering.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_wanted && !hold_used) begin
         hold_used = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 20);
      end
   end

   // Result checker: every accepted result word is matched against the oldest
   // expectation, field by field.
   always @(posedge clock) begin : check_results
      filter_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (pending_words.size() == 0) begin
            report($sformatf("result word %0d arrived with none expected: %0d",
                             result_count, rsp_sample_out));
         end else begin
            want = pending_words.pop_front();
            if (rsp_sample_out !== want.smp) begin
               report($sformatf("result word %0d: sample_out %0d, expected %0d",
                                result_count, rsp_sample_out, want.smp));
            end
            if (rsp_block_end_out !== want.be) begin
               report($sformatf("result word %0d: block_end_out %b, expected %b",
                                result_count, rsp_block_end_out, want.be));
            end
            if (rsp_clipped !== want.clip) begin
               report($sformatf("result word %0d: clipped %b, expected %b",
                                result_count, rsp_clipped, want.clip));
            end
         end
      end
   end

   // Watchdog: a long run of cycles in which no word moves on either channel and the
   // configuration port is quiet means the block has hung.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("iir_direct_form_ii_filter_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      step_type     step;
      cfg_mode_type mode;
      for (int n = 0; n < TAPS; n++) begin
         delay_taps[n] = '0;
      end
      for (int n = 0; n < 4; n++) begin
         den_q28[n] = '0;
         num_q28[n] = '0;
      end
      den_q28[0] = COEF_ONE;
      num_q28[0] = COEF_ONE;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: walk the table. Register rows wait for the block to drain.
      for (int i = 0; i < N_STEPS; i++) begin
         step = directed_steps[i];
         if (step.kind == STEP_CSR) begin
            settle();
            write_coef(step.reg_id, step.coef);
         end else begin
            push_word(step.smp, step.be, step.kind == STEP_FIXED,
                      '{smp: step.want_smp, be: step.be, clip: step.want_clip});
         end
      end

      // Random part: each phase loads a fresh coefficient set while the block is
      // idle, then streams random words. The third phase runs with no idling on
      // either side, and the second triggers the long receiver hold-off.
      for (int phase = 0; phase < N_PHASES; phase++) begin
         settle();
         calm = (phase == 2);
         mode = cfg_mode_type'(phase % 4);
         for (int r = 0; r < N_REGS; r++) begin
            write_coef(csr_reg_type'(r), rand_coef(mode, csr_reg_type'(r)));
         end
         for (int k = 0; k < PHASE_WORDS; k++) begin
            push_word(rand_sample(), $urandom_range(7) == 0, 1'b0, '0);
            if (phase == 1 && k == 20) hold_wanted = 1'b1;
         end
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("iir_direct_form_ii_filter_tb: clean");
      end else begin
         $display("iir_direct_form_ii_filter_tb: errors");
      end
      $finish;
   end

endmodule
